@@ design/sspc_pkg.sv @@
// shared types and constants for the servo status packet checker
`timescale 1ns / 1ps

package sspc_pkg;

    localparam int MAX_PACKET_DEF   = 64;
    localparam int RECORD_BYTES_DEF = 44;

    localparam int BYTE_W   = 8;
    localparam int NPARAM_W = 7;
    localparam int OFFSET_W = 6;
    localparam int CFG_IDX_W = 1;

    localparam logic [BYTE_W-1:0] HEADER_BYTE = 8'hFF;

    localparam int ID_POS     = 2;
    localparam int LENGTH_POS = 3;
    localparam int PARAM_POS  = 5;
    localparam int MIN_PACKET = 6;
    localparam int LEN_BIAS   = 4;

    localparam logic [CFG_IDX_W-1:0] REG_FIRST_ID  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_SECOND_ID = 1'b1;

    typedef enum logic [2:0] {
        ST_OK     = 3'd0,
        ST_HEADER = 3'd1,
        ST_SUM    = 3'd2,
        ST_LENGTH = 3'd3,
        ST_ID     = 3'd4,
        ST_SIZE   = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_READ,
        BK_SHOW
    } back_state_t;

    typedef struct packed {
        status_t               status;
        logic                  slot;
        logic [NPARAM_W-1:0]   nparam;
        logic                  bank;
    } pkt_desc_t;

endpackage

@@ design/sspc_front.sv @@
// front end: byte capture, running sum and packet judgement
`timescale 1ns / 1ps

module sspc_front #(
    parameter int MAX_PACKET   = sspc_pkg::MAX_PACKET_DEF,
    parameter int RECORD_BYTES = sspc_pkg::RECORD_BYTES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [sspc_pkg::BYTE_W-1:0]     s_tdata,
    input  logic                            s_tlast,
    input  logic                            cfg_we,
    input  logic [sspc_pkg::CFG_IDX_W-1:0]  cfg_addr,
    input  logic [sspc_pkg::BYTE_W-1:0]     cfg_wdata,
    input  logic                            q_full,
    output logic                            push,
    output sspc_pkg::pkt_desc_t             push_desc,
    output logic                            wr_en,
    output logic [$clog2(MAX_PACKET):0]     wr_addr,
    output logic [sspc_pkg::BYTE_W-1:0]     wr_data
);

    localparam int AW    = $clog2(MAX_PACKET);
    localparam int CNT_W = $clog2(MAX_PACKET + 1);
    localparam int CMP_W = (CNT_W > sspc_pkg::BYTE_W) ? CNT_W : sspc_pkg::BYTE_W;

    logic [sspc_pkg::BYTE_W-1:0] first_id_reg, second_id_reg;
    logic [CNT_W-1:0]            cnt_reg, cnt_next;
    logic [sspc_pkg::BYTE_W-1:0] sum_reg, sum_next;
    logic                        ovf_reg, ovf_next;
    logic                        bank_reg, bank_next;
    logic [sspc_pkg::BYTE_W-1:0] h0_reg, h1_reg, id_reg, lenb_reg;

    logic                        acc;
    logic                        full;
    logic [CNT_W-1:0]            len;
    logic [CNT_W-1:0]            np_full;
    sspc_pkg::status_t           status;
    logic                        slot;
    logic [sspc_pkg::NPARAM_W-1:0] nparam;

    assign s_tready = !q_full;
    assign acc      = s_tvalid && s_tready;
    assign full     = (cnt_reg == CNT_W'(MAX_PACKET));
    assign len      = full ? cnt_reg : cnt_reg + CNT_W'(1);
    assign np_full  = len - CNT_W'(sspc_pkg::MIN_PACKET);

    assign wr_en   = acc && !full;
    assign wr_addr = {bank_reg, cnt_reg[AW-1:0]};
    assign wr_data = s_tdata;

    // judgement, first failing check wins
    always_comb
    begin
        status = sspc_pkg::ST_OK;
        slot   = 1'b0;
        if (ovf_reg || full || (len < CNT_W'(sspc_pkg::MIN_PACKET)))
        begin
            status = sspc_pkg::ST_SIZE;
        end
        else if ((h0_reg != sspc_pkg::HEADER_BYTE) || (h1_reg != sspc_pkg::HEADER_BYTE))
        begin
            status = sspc_pkg::ST_HEADER;
        end
        else if (~sum_reg != s_tdata)
        begin
            status = sspc_pkg::ST_SUM;
        end
        else if (CMP_W'(lenb_reg) != CMP_W'(len) - CMP_W'(sspc_pkg::LEN_BIAS))
        begin
            status = sspc_pkg::ST_LENGTH;
        end
        else if (id_reg == first_id_reg)
        begin
            slot = 1'b0;
        end
        else if (id_reg == second_id_reg)
        begin
            slot = 1'b1;
        end
        else
        begin
            status = sspc_pkg::ST_ID;
        end
    end

    always_comb
    begin
        if (int'(np_full) > RECORD_BYTES)
            nparam = sspc_pkg::NPARAM_W'(RECORD_BYTES);
        else
            nparam = sspc_pkg::NPARAM_W'(np_full);
    end

    assign push             = acc && s_tlast;
    assign push_desc.status = status;
    assign push_desc.slot   = slot;
    assign push_desc.nparam = nparam;
    assign push_desc.bank   = bank_reg;

    always_comb
    begin
        cnt_next  = cnt_reg;
        sum_next  = sum_reg;
        ovf_next  = ovf_reg;
        bank_next = bank_reg;
        if (acc)
        begin
            if (full)
            begin
                ovf_next = 1'b1;
            end
            else
            begin
                if (!s_tlast && (cnt_reg >= CNT_W'(sspc_pkg::ID_POS)))
                    sum_next = sum_reg + s_tdata;
                cnt_next = cnt_reg + CNT_W'(1);
            end
            if (s_tlast)
            begin
                cnt_next  = '0;
                sum_next  = '0;
                ovf_next  = 1'b0;
                bank_next = !bank_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_id_reg  <= 8'd1;
            second_id_reg <= 8'd2;
            cnt_reg       <= '0;
            sum_reg       <= '0;
            ovf_reg       <= 1'b0;
            bank_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_we && (cfg_addr == sspc_pkg::REG_FIRST_ID))
                first_id_reg <= cfg_wdata;
            if (cfg_we && (cfg_addr == sspc_pkg::REG_SECOND_ID))
                second_id_reg <= cfg_wdata;
            cnt_reg  <= cnt_next;
            sum_reg  <= sum_next;
            ovf_reg  <= ovf_next;
            bank_reg <= bank_next;
        end
    end

    // header fields captured at their fixed positions
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            if (cnt_reg == CNT_W'(0))
                h0_reg <= s_tdata;
            if (cnt_reg == CNT_W'(1))
                h1_reg <= s_tdata;
            if (cnt_reg == CNT_W'(sspc_pkg::ID_POS))
                id_reg <= s_tdata;
            if (cnt_reg == CNT_W'(sspc_pkg::LENGTH_POS))
                lenb_reg <= s_tdata;
        end
    end

endmodule

@@ design/sspc_queue.sv @@
// two-entry queue of judged packet descriptors
`timescale 1ns / 1ps

module sspc_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  sspc_pkg::pkt_desc_t  push_desc,
    input  logic                 pop,
    output sspc_pkg::pkt_desc_t  head,
    output logic                 full,
    output logic                 empty
);

    sspc_pkg::pkt_desc_t entry_reg [2];
    logic                wp_reg, rp_reg;
    logic [1:0]          count_reg, count_next;

    assign full  = (count_reg == 2'd2);
    assign empty = (count_reg == 2'd0);
    assign head  = entry_reg[rp_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 2'd1;
        else if (pop && !push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg    <= 1'b0;
            rp_reg    <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
                wp_reg <= !wp_reg;
            if (pop)
                rp_reg <= !rp_reg;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wp_reg] <= push_desc;
    end

endmodule

@@ design/sspc_back.sv @@
// back end: two-bank packet memory and parameter byte replay
`timescale 1ns / 1ps

module sspc_back #(
    parameter int MAX_PACKET = sspc_pkg::MAX_PACKET_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          wr_en,
    input  logic [$clog2(MAX_PACKET):0]   wr_addr,
    input  logic [sspc_pkg::BYTE_W-1:0]   wr_data,
    input  logic                          q_empty,
    input  sspc_pkg::pkt_desc_t           head,
    output logic                          pop,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [23:0]                   m_tdata,
    output logic                          m_tuser,
    output logic                          m_tlast
);

    localparam int AW    = $clog2(MAX_PACKET);
    localparam int DEPTH = 2 * MAX_PACKET;

    logic [sspc_pkg::BYTE_W-1:0] mem [DEPTH];
    logic [sspc_pkg::BYTE_W-1:0] rd_data_reg;

    sspc_pkg::back_state_t state_reg, state_next;
    sspc_pkg::pkt_desc_t   desc_reg;
    logic [sspc_pkg::OFFSET_W-1:0] idx_reg;

    sspc_pkg::status_t             o_status_reg;
    logic                          o_slot_reg;
    logic                          o_carries_reg;
    logic [sspc_pkg::OFFSET_W-1:0] o_offset_reg;
    logic [sspc_pkg::BYTE_W-1:0]   o_value_reg;
    logic                          o_last_reg;

    logic                          rd_en;
    logic                          rd_bank;
    logic [sspc_pkg::OFFSET_W-1:0] rd_idx;
    logic [AW:0]                   rd_addr;
    logic                          single;

    assign single  = (head.status != sspc_pkg::ST_OK) || (head.nparam == '0);
    assign rd_addr = {rd_bank, AW'(rd_idx) + AW'(sspc_pkg::PARAM_POS)};

    assign m_tdata = {6'b0, o_value_reg, o_offset_reg, o_slot_reg, o_status_reg};
    assign m_tuser = o_carries_reg;
    assign m_tlast = o_last_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sspc_pkg::BK_IDLE:
            begin
                if (!q_empty)
                    state_next = single ? sspc_pkg::BK_SHOW : sspc_pkg::BK_READ;
            end
            sspc_pkg::BK_READ:
            begin
                state_next = sspc_pkg::BK_SHOW;
            end
            sspc_pkg::BK_SHOW:
            begin
                if (m_tready)
                    state_next = o_last_reg ? sspc_pkg::BK_IDLE : sspc_pkg::BK_READ;
            end
            default:
            begin
                state_next = sspc_pkg::BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rd_en    = 1'b0;
        rd_bank  = desc_reg.bank;
        rd_idx   = idx_reg + sspc_pkg::OFFSET_W'(1);
        pop      = 1'b0;
        m_tvalid = 1'b0;
        unique case (state_reg)
            sspc_pkg::BK_IDLE:
            begin
                rd_en   = !q_empty && !single;
                rd_bank = head.bank;
                rd_idx  = '0;
            end
            sspc_pkg::BK_READ:
            begin
                rd_en = 1'b0;
            end
            sspc_pkg::BK_SHOW:
            begin
                m_tvalid = 1'b1;
                pop      = m_tready && o_last_reg;
                rd_en    = m_tready && !o_last_reg;
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= sspc_pkg::BK_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == sspc_pkg::BK_IDLE && !q_empty)
        begin
            desc_reg      <= head;
            idx_reg       <= '0;
            o_status_reg  <= head.status;
            o_slot_reg    <= (head.status == sspc_pkg::ST_OK) ? head.slot : 1'b0;
            o_carries_reg <= 1'b0;
            o_offset_reg  <= '0;
            o_value_reg   <= '0;
            o_last_reg    <= 1'b1;
        end
        else if (state_reg == sspc_pkg::BK_READ)
        begin
            o_status_reg  <= sspc_pkg::ST_OK;
            o_slot_reg    <= desc_reg.slot;
            o_carries_reg <= 1'b1;
            o_offset_reg  <= idx_reg;
            o_value_reg   <= rd_data_reg;
            o_last_reg    <= (sspc_pkg::NPARAM_W'(idx_reg) + sspc_pkg::NPARAM_W'(1)
                              == desc_reg.nparam);
        end
        else if (state_reg == sspc_pkg::BK_SHOW && m_tready && !o_last_reg)
        begin
            idx_reg <= idx_reg + sspc_pkg::OFFSET_W'(1);
        end
    end

endmodule

@@ design/servo_status_packet_checker_core.sv @@
// top level of the servo status packet checker
// a rejected or empty packet gives one result beat loaded straight from the queued descriptor; a packet with
// parameter bytes replays one beat per byte, each read from the packet memory and registered in READ before SHOW
// throughput: 1 byte per cycle in while the queue is not full; replay paced by the registered packet memory read
// the two-bank memory and two-entry queue let the next packet arrive during replay
// reset: async active low, ids return to 1 and 2, counters and queue cleared, memory not cleared
`timescale 1ns / 1ps

module servo_status_packet_checker_core #(
    parameter int MAX_PACKET   = sspc_pkg::MAX_PACKET_DEF,
    parameter int RECORD_BYTES = sspc_pkg::RECORD_BYTES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,  // rx_byte
    input  logic                            s_tlast,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [23:0]                     m_tdata,  // status, servo_slot, byte_offset, byte_value
    output logic                            m_tuser,  // carries_byte
    output logic                            m_tlast,
    input  logic                            cfg_we,
    input  logic [sspc_pkg::CFG_IDX_W-1:0]  cfg_addr,
    input  logic [7:0]                      cfg_wdata
);

    localparam int AW = $clog2(MAX_PACKET);

    logic                push;
    sspc_pkg::pkt_desc_t push_desc;
    sspc_pkg::pkt_desc_t head;
    logic                pop, q_full, q_empty;
    logic                wr_en;
    logic [AW:0]         wr_addr;
    logic [7:0]          wr_data;

    sspc_front #(
        .MAX_PACKET   (MAX_PACKET),
        .RECORD_BYTES (RECORD_BYTES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .q_full    (q_full),
        .push      (push),
        .push_desc (push_desc),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data)
    );

    sspc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_desc (push_desc),
        .pop       (pop),
        .head      (head),
        .full      (q_full),
        .empty     (q_empty)
    );

    sspc_back #(
        .MAX_PACKET (MAX_PACKET)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data),
        .q_empty  (q_empty),
        .head     (head),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

@@ tb/servo_status_packet_checker_core_tb.sv @@
// self-checking testbench for the servo status packet checker: random packets, predicted replay
`timescale 1ns / 1ps

module servo_status_packet_checker_core_tb;

    localparam int QUIET_LIMIT = 2000;
    localparam int PKT_BUF     = 72;

    typedef enum {
        PK_GOOD,
        PK_HEADER,
        PK_SUM,
        PK_LENGTH,
        PK_ID,
        PK_SHORT,
        PK_OVERFLOW,
        PK_NOISE
    } pkt_kind_t;

    typedef struct {
        logic [7:0] data;
        logic       eop;
    } rx_item_t;

    typedef struct {
        sspc_pkg::status_t status;
        logic              slot;
        logic              carries;
        logic [5:0]        offset;
        logic [7:0]        value;
        logic              last;
    } servo_beat_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;   // status, servo_slot, byte_offset, byte_value
    logic        m_tuser;   // carries_byte
    logic        m_tlast;
    logic        cfg_we = 1'b0;
    logic [sspc_pkg::CFG_IDX_W-1:0] cfg_addr = sspc_pkg::REG_FIRST_ID;
    logic [7:0]  cfg_wdata = 8'h00;

    servo_status_packet_checker_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // stimulus and expectation stores
    rx_item_t    rx_q[$];
    servo_beat_t replay_q[$];
    int          beats_queued = 0;
    int          beats_taken = 0;
    bit          beat_taken = 1'b0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          err_count = 0;
    int          quiet_cycles = 0;
    bit          moved;

    // predictor state
    logic [7:0]  slot0_id = 8'd1;
    logic [7:0]  slot1_id = 8'd2;
    logic [7:0]  rx_buf [0:sspc_pkg::MAX_PACKET_DEF-1];
    int          rx_count = 0;
    logic [7:0]  rx_sum = 8'h00;
    bit          rx_over = 1'b0;

    task automatic report(input string field, input int unsigned want, input int unsigned got);
        $display("%0t mismatch in %s: expected %0d, got %0d", $time, field, want, got);
        err_count++;
    endtask

    task automatic judge_rx_byte(input logic [7:0] b, input logic eop);
        int                len;
        int                nparam;
        int                i;
        logic              slot;
        sspc_pkg::status_t st;
        logic [7:0]        chk;
        servo_beat_t       r;
        if (rx_count >= sspc_pkg::MAX_PACKET_DEF)
            rx_over = 1'b1;
        else
        begin
            rx_buf[rx_count] = b;
            if (!eop && rx_count >= sspc_pkg::ID_POS)
                rx_sum = rx_sum + b;
            rx_count++;
        end
        if (!eop)
            return;
        len = rx_count;
        slot = 1'b0;
        chk = ~rx_sum;
        if (rx_over || len < sspc_pkg::MIN_PACKET)
            st = sspc_pkg::ST_SIZE;
        else if (rx_buf[0] != sspc_pkg::HEADER_BYTE || rx_buf[1] != sspc_pkg::HEADER_BYTE)
            st = sspc_pkg::ST_HEADER;
        else if (chk != rx_buf[len-1])
            st = sspc_pkg::ST_SUM;
        else if (int'(rx_buf[sspc_pkg::LENGTH_POS]) != len - sspc_pkg::LEN_BIAS)
            st = sspc_pkg::ST_LENGTH;
        else if (rx_buf[sspc_pkg::ID_POS] == slot0_id)
            st = sspc_pkg::ST_OK;
        else if (rx_buf[sspc_pkg::ID_POS] == slot1_id)
        begin
            st = sspc_pkg::ST_OK;
            slot = 1'b1;
        end
        else
            st = sspc_pkg::ST_ID;
        r.status = st;
        r.slot = 1'b0;
        r.carries = 1'b0;
        r.offset = '0;
        r.value = '0;
        r.last = 1'b1;
        if (st != sspc_pkg::ST_OK)
            replay_q.push_back(r);
        else
        begin
            nparam = len - sspc_pkg::MIN_PACKET;
            if (nparam > sspc_pkg::RECORD_BYTES_DEF)
                nparam = sspc_pkg::RECORD_BYTES_DEF;
            r.slot = slot;
            if (nparam == 0)
                replay_q.push_back(r);
            for (i = 0; i < nparam; i++)
            begin
                r.carries = 1'b1;
                r.offset = 6'(i);
                r.value = rx_buf[sspc_pkg::PARAM_POS + i];
                r.last = (i + 1 == nparam);
                replay_q.push_back(r);
            end
        end
        rx_count = 0;
        rx_sum = 8'h00;
        rx_over = 1'b0;
    endtask

    task automatic check_beat();
        servo_beat_t e;
        if (replay_q.size() == 0)
        begin
            report("beat with nothing pending", 0, m_tdata);
            return;
        end
        e = replay_q.pop_front();
        if (m_tdata[2:0] !== e.status)
            report("status", e.status, m_tdata[2:0]);
        if (m_tdata[3] !== e.slot)
            report("servo_slot", e.slot, m_tdata[3]);
        if (m_tuser !== e.carries)
            report("carries_byte", e.carries, m_tuser);
        if (m_tdata[9:4] !== e.offset)
            report("byte_offset", e.offset, m_tdata[9:4]);
        if (m_tdata[17:10] !== e.value)
            report("byte_value", e.value, m_tdata[17:10]);
        if (m_tlast !== e.last)
            report("last", e.last, m_tlast);
    endtask

    // monitor, predictor feed and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            moved = 1'b0;
            if (s_tvalid && s_tready)
            begin
                judge_rx_byte(s_tdata, s_tlast);
                beats_taken++;
                beat_taken = 1'b1;
                moved = 1'b1;
            end
            if (m_tvalid && m_tready)
            begin
                check_beat();
                moved = 1'b1;
            end
            if (moved)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("servo_status_packet_checker_core test failed");
                $finish;
            end
        end
    end

    // driver
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            m_tready <= 1'b0;
        end
        else
        begin
            if (!s_tvalid || beat_taken)
            begin
                if (rx_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    s_tvalid <= 1'b1;
                    s_tdata <= rx_q[0].data;
                    s_tlast <= rx_q[0].eop;
                    rx_q.delete(0);
                end
                else
                    s_tvalid <= 1'b0;
            end
            beat_taken = 1'b0;
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic eop);
        rx_item_t it;
        it.data = b;
        it.eop = eop;
        rx_q.push_back(it);
        beats_queued++;
    endtask

    task automatic queue_packet(input pkt_kind_t kind, input int nparam);
        logic [7:0] pk [0:PKT_BUF-1];
        int         len;
        int         i;
        logic [7:0] sum;
        len = nparam + sspc_pkg::MIN_PACKET;
        for (i = 0; i < PKT_BUF; i++)
            pk[i] = 8'($urandom_range(255));
        pk[0] = sspc_pkg::HEADER_BYTE;
        pk[1] = sspc_pkg::HEADER_BYTE;
        pk[sspc_pkg::ID_POS] = ($urandom_range(1) == 0) ? slot0_id : slot1_id;
        case (kind)
            PK_HEADER:
                if ($urandom_range(1) == 0)
                    pk[0] = 8'($urandom_range(254));
                else
                    pk[1] = 8'($urandom_range(254));
            PK_ID:
                while (pk[sspc_pkg::ID_POS] == slot0_id || pk[sspc_pkg::ID_POS] == slot1_id)
                    pk[sspc_pkg::ID_POS] = 8'($urandom_range(255));
            PK_SHORT:
                len = $urandom_range(sspc_pkg::MIN_PACKET - 1, 1);
            PK_OVERFLOW:
                len = $urandom_range(PKT_BUF, sspc_pkg::MAX_PACKET_DEF + 1);
            default:
                ;
        endcase
        pk[sspc_pkg::LENGTH_POS] = 8'(len - sspc_pkg::LEN_BIAS);
        if (kind == PK_LENGTH)
            pk[sspc_pkg::LENGTH_POS] = pk[sspc_pkg::LENGTH_POS] + 8'($urandom_range(255, 1));
        sum = 8'h00;
        for (i = sspc_pkg::ID_POS; i < len - 1; i++)
            sum = sum + pk[i];
        pk[len-1] = ~sum;
        if (kind == PK_SUM)
            pk[len-1] = pk[len-1] ^ 8'($urandom_range(255, 1));
        if (kind == PK_NOISE)
        begin
            len = $urandom_range(12, 1);
            for (i = 0; i < len; i++)
                pk[i] = 8'($urandom_range(255));
        end
        for (i = 0; i < len; i++)
            send_byte(pk[i], i == len - 1);
    endtask

    function automatic pkt_kind_t pick_kind();
        int r;
        r = $urandom_range(99);
        if (r < 55)
            return PK_GOOD;
        else if (r < 62)
            return PK_HEADER;
        else if (r < 70)
            return PK_SUM;
        else if (r < 77)
            return PK_LENGTH;
        else if (r < 84)
            return PK_ID;
        else if (r < 89)
            return PK_SHORT;
        else if (r < 93)
            return PK_OVERFLOW;
        return PK_NOISE;
    endfunction

    // mostly short records, a few near or past the record size
    function automatic int pick_nparam();
        int r;
        r = $urandom_range(99);
        if (r < 70)
            return $urandom_range(6, 0);
        else if (r < 90)
            return $urandom_range(20, 7);
        return $urandom_range(sspc_pkg::MAX_PACKET_DEF - sspc_pkg::MIN_PACKET,
                              sspc_pkg::RECORD_BYTES_DEF - 4);
    endfunction

    task automatic wait_drained();
        while (beats_taken != beats_queued || replay_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_id(input logic [sspc_pkg::CFG_IDX_W-1:0] idx, input logic [7:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == sspc_pkg::REG_FIRST_ID)
            slot0_id = val;
        else
            slot1_id = val;
    endtask

    task automatic run_random(input int idle_pct, input int stall_pct, input int n_items);
        int start;
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        start = beats_queued;
        while (beats_queued - start < n_items)
            queue_packet(pick_kind(), pick_nparam());
        wait_drained();
        repeat (10) @(negedge clk);
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: lone final byte, empty record, bad header, bad sum, one parameter byte
        send_byte(8'h00, 1'b1);
        queue_packet(PK_GOOD, 0);
        queue_packet(PK_HEADER, 0);
        queue_packet(PK_SUM, 0);
        queue_packet(PK_GOOD, 1);
        run_random(0, 0, 70);

        write_id(sspc_pkg::REG_FIRST_ID, 8'd0);
        write_id(sspc_pkg::REG_SECOND_ID, 8'd253);
        run_random(78, 0, 110);

        // equal ids: slot 0 wins
        write_id(sspc_pkg::REG_FIRST_ID, 8'd253);
        run_random(0, 78, 110);

        write_id(sspc_pkg::REG_FIRST_ID, 8'($urandom_range(253)));
        write_id(sspc_pkg::REG_SECOND_ID, 8'($urandom_range(253)));
        run_random(27, 27, 110);

        wait_drained();
        repeat (20) @(posedge clk);
        if (err_count == 0 && replay_q.size() == 0)
            $display("servo_status_packet_checker_core test passed");
        else
            $display("servo_status_packet_checker_core test failed");
        $finish;
    end

endmodule
